/* hdl/pscb_pkg.sv */
`timescale 1ns / 1ps

package pscb_pkg;

   // Default table depth.
   localparam int MAX_ENTRIES_DEF = 64;

   // Shortest valid IP header, in 32-bit words (20 bytes).
   localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;

   localparam logic [31:0] INTERVAL_TICKS_RESET = 32'd1000000;

   // Function codes of an input item.
   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_PACKET = 2'd1;
   localparam logic [1:0] FUNC_DUMP   = 2'd2;

   // Report kinds.
   localparam logic KIND_INTERVAL = 1'b0;
   localparam logic KIND_TOTALS   = 1'b1;

   // Register indexes (byte address / 4).
   localparam logic [2:0] REG_OWN_ADDR        = 3'd0;
   localparam logic [2:0] REG_HOST_COUNT      = 3'd1;
   localparam logic [2:0] REG_UPDATES_ENABLED = 3'd2;
   localparam logic [2:0] REG_INTERVAL_TICKS  = 3'd3;
   localparam logic [2:0] REG_START_TIME      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_UPDATE = 3'b010,
      ST_RUN    = 3'b100
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  entry_index;
      logic [31:0] entry_addr;
      logic [3:0]  header_words;
      logic [31:0] src_addr;
      logic [15:0] pkt_bytes;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic        report_kind;
      logic [5:0]  host_index;
      logic [31:0] interval_bytes;
      logic [47:0] total_bytes;
      logic [31:0] elapsed_ticks;
      logic [31:0] report_time;
      logic        last;
   } rsp_type;

   // Contents of one table entry.
   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] ival;
      logic [47:0] total;
   } entry_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic        load_en;
      logic [5:0]  load_index;
      logic [31:0] load_addr;
      logic        capture_en;
      logic [31:0] src_addr;
      logic [6:0]  host_count;
      logic        count_en;
      logic [15:0] pkt_bytes;
      logic        shift_en;
   } cell_ctrl_type;

endpackage

/* hdl/pscb_cell.sv */
`timescale 1ns / 1ps

module pscb_cell #(
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pscb_pkg::cell_ctrl_type ctrl,
   input  pscb_pkg::entry_type     nbr_entry,
   input  logic                    above_in,
   output logic                    above_out,
   output pscb_pkg::entry_type     entry
);

   logic [31:0] addr_ff, addr_in;
   logic [31:0] ival_ff, ival_in;
   logic [47:0] total_ff, total_in;
   logic        match_ff, match_in;
   logic        in_use;
   logic        load_hit;
   logic        count_hit;
   logic [32:0] ival_sum;
   logic [48:0] total_sum;

   assign in_use    = 32'(ctrl.host_count) > 32'(INDEX);
   assign load_hit  = ctrl.load_en && (32'(ctrl.load_index) == 32'(INDEX));
   // The highest matching slot takes the packet: lower slots see a match above.
   assign count_hit = ctrl.count_en && match_ff && !above_in;
   assign above_out = above_in || match_ff;

   assign ival_sum  = {1'b0, ival_ff} + 33'(ctrl.pkt_bytes);
   assign total_sum = {1'b0, total_ff} + 49'(ctrl.pkt_bytes);

   always_comb begin
      addr_in  = addr_ff;
      ival_in  = ival_ff;
      total_in = total_ff;
      match_in = match_ff;
      if (load_hit) begin
         addr_in  = ctrl.load_addr;
         ival_in  = '0;
         total_in = '0;
      end else if (count_hit) begin
         ival_in  = ival_sum[32] ? '1 : ival_sum[31:0];
         total_in = total_sum[48] ? '1 : total_sum[47:0];
      end else if (ctrl.shift_en) begin
         addr_in  = nbr_entry.addr;
         ival_in  = nbr_entry.ival;
         total_in = nbr_entry.total;
      end
      if (ctrl.capture_en) begin
         match_in = in_use && (addr_ff == ctrl.src_addr);
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ival_ff  <= '0;
         total_ff <= '0;
         match_ff <= 1'b0;
      end else begin
         ival_ff  <= ival_in;
         total_ff <= total_in;
         match_ff <= match_in;
      end
   end

   assign entry.addr  = addr_ff;
   assign entry.ival  = ival_ff;
   assign entry.total = total_ff;

endmodule

/* hdl/per_source_ip_byte_counters_core.sv */
`timescale 1ns / 1ps

// Per-source byte counters. The table lives in a row of MAX_ENTRIES cells, one
// per slot, each holding a watched address, a saturating 32-bit interval count
// and a saturating 48-bit total. A load transfer writes its slot directly. For
// a packet that passes the header and source checks, every cell compares the
// source address in the cycle the transfer is accepted; the match is registered
// and the highest matching slot adds the packet length in the update state. A
// report run (an elapsed interval, or a dump) rotates the whole row once through
// cell 0, one slot a cycle while the result side does not stall; one result
// leaves per slot in use, in slot order, with last set on the final one. Input
// is stalled during the update state and during a run. Results sit in an output
// register, so a new transfer is taken while the final result still waits.
// Registers are to be written through the APB-style port only while the block
// is idle; the block itself does not enforce this. csr_pready is always high.
module per_source_ip_byte_counters_core #(
   parameter int MAX_ENTRIES = pscb_pkg::MAX_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // Input channel
   input  logic              req_valid,
   output logic              req_stall,
   input  pscb_pkg::req_type req_data,
   // Result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pscb_pkg::rsp_type rsp_data,
   // Configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   // Configuration registers.
   logic [31:0] own_addr_ff;
   logic [6:0]  host_count_ff;
   logic        updates_enabled_ff;
   logic [31:0] interval_ticks_ff;
   logic [31:0] start_time_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff        <= '0;
         host_count_ff      <= '0;
         updates_enabled_ff <= 1'b0;
         interval_ticks_ff  <= pscb_pkg::INTERVAL_TICKS_RESET;
         start_time_ff      <= '0;
      end else if (csr_write) begin
         case (csr_index)
            pscb_pkg::REG_OWN_ADDR:        own_addr_ff        <= csr_pwdata;
            pscb_pkg::REG_HOST_COUNT:      host_count_ff      <= csr_pwdata[6:0];
            pscb_pkg::REG_UPDATES_ENABLED: updates_enabled_ff <= csr_pwdata[0];
            pscb_pkg::REG_INTERVAL_TICKS:  interval_ticks_ff  <= csr_pwdata;
            pscb_pkg::REG_START_TIME:      start_time_ff      <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         pscb_pkg::REG_OWN_ADDR:        csr_prdata = own_addr_ff;
         pscb_pkg::REG_HOST_COUNT:      csr_prdata = 32'(host_count_ff);
         pscb_pkg::REG_UPDATES_ENABLED: csr_prdata = 32'(updates_enabled_ff);
         pscb_pkg::REG_INTERVAL_TICKS:  csr_prdata = interval_ticks_ff;
         pscb_pkg::REG_START_TIME:      csr_prdata = start_time_ff;
         default:                       csr_prdata = '0;
      endcase
   end

   // Sequencer state.
   pscb_pkg::state_type state_ff, state_in;
   logic [31:0]      now_ff, now_in;
   logic [15:0]      plen_ff, plen_in;
   logic             kind_ff, kind_in;
   logic [31:0]      elapsed_ff, elapsed_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      last_report_ff, last_report_in;
   logic             reported_once_ff, reported_once_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pscb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        packet_ok;
   logic [31:0] ref_time;
   logic [31:0] since_ref;
   logic        run_due;
   logic        emit;
   logic        is_last;
   logic        out_free;
   logic        advance;
   logic [31:0] pos_wide;
   logic [31:0] count_wide;

   pscb_pkg::cell_ctrl_type ctrl;
   pscb_pkg::entry_type     cell_q [MAX_ENTRIES];
   logic                    above  [MAX_ENTRIES];
   pscb_pkg::entry_type     wrap_entry;

   assign req_stall = (state_ff != pscb_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign packet_ok = (req_data.header_words >= pscb_pkg::MIN_HEADER_WORDS)
                      && (req_data.src_addr != own_addr_ff);

   // Interval check for the packet held in the update cycle.
   assign ref_time  = reported_once_ff ? last_report_ff : start_time_ff;
   assign since_ref = now_ff - ref_time;
   assign run_due   = updates_enabled_ff && (interval_ticks_ff <= since_ref);

   // Report run: slots below the in-use count give results, the rest only
   // rotate back into place.
   assign pos_wide   = 32'(pos_ff);
   assign count_wide = 32'(host_count_ff);
   assign emit       = pos_wide < count_wide;
   assign is_last    = (pos_wide + 32'd1 == count_wide)
                       || (pos_wide == 32'(MAX_ENTRIES - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = (state_ff == pscb_pkg::ST_RUN) && (!emit || out_free);

   // Entry re-entering the far end of the row; an interval run clears its interval
   always_comb begin
      wrap_entry = cell_q[0];
      if (kind_ff == pscb_pkg::KIND_INTERVAL && emit) begin
         wrap_entry.ival = '0;
      end
   end

   always_comb begin
      ctrl.load_en    = accept && (req_data.func == pscb_pkg::FUNC_LOAD);
      ctrl.load_index = req_data.entry_index;
      ctrl.load_addr  = req_data.entry_addr;
      ctrl.capture_en = accept && (req_data.func == pscb_pkg::FUNC_PACKET) && packet_ok;
      ctrl.src_addr   = req_data.src_addr;
      ctrl.host_count = host_count_ff;
      ctrl.count_en   = (state_ff == pscb_pkg::ST_UPDATE);
      ctrl.pkt_bytes  = plen_ff;
      ctrl.shift_en   = advance;
   end

   always_comb begin
      state_in         = state_ff;
      now_in           = now_ff;
      plen_in          = plen_ff;
      kind_in          = kind_ff;
      elapsed_in       = elapsed_ff;
      pos_in           = pos_ff;
      last_report_in   = last_report_ff;
      reported_once_in = reported_once_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_data_in      = rsp_data_ff;
      case (state_ff)
         pscb_pkg::ST_IDLE: begin
            if (accept) begin
               now_in  = req_data.now_time;
               plen_in = req_data.pkt_bytes;
               pos_in  = '0;
               if (ctrl.capture_en) begin
                  state_in = pscb_pkg::ST_UPDATE;
               end else if (req_data.func == pscb_pkg::FUNC_DUMP) begin
                  kind_in    = pscb_pkg::KIND_TOTALS;
                  elapsed_in = req_data.now_time - start_time_ff;
                  state_in   = pscb_pkg::ST_RUN;
               end
            end
         end
         pscb_pkg::ST_UPDATE: begin
            if (run_due) begin
               kind_in          = pscb_pkg::KIND_INTERVAL;
               elapsed_in       = since_ref;
               last_report_in   = now_ff;
               reported_once_in = 1'b1;
               state_in         = pscb_pkg::ST_RUN;
            end else begin
               state_in = pscb_pkg::ST_IDLE;
            end
         end
         pscb_pkg::ST_RUN: begin
            if (advance) begin
               if (emit) begin
                  rsp_valid_in               = 1'b1;
                  rsp_data_in.report_kind    = kind_ff;
                  rsp_data_in.host_index     = 6'(pos_ff);
                  rsp_data_in.interval_bytes = cell_q[0].ival;
                  rsp_data_in.total_bytes    = cell_q[0].total;
                  rsp_data_in.elapsed_ticks  = elapsed_ff;
                  rsp_data_in.report_time    = now_ff;
                  rsp_data_in.last           = is_last;
               end
               if (pos_wide == 32'(MAX_ENTRIES - 1)) begin
                  state_in = pscb_pkg::ST_IDLE;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         default: state_in = pscb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= pscb_pkg::ST_IDLE;
         pos_ff           <= '0;
         last_report_ff   <= '0;
         reported_once_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pos_ff           <= pos_in;
         last_report_ff   <= last_report_in;
         reported_once_ff <= reported_once_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      plen_ff     <= plen_in;
      kind_ff     <= kind_in;
      elapsed_ff  <= elapsed_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The row of cells. Data moves towards cell 0 during a run, and the match
   // flags are passed from the top slot downwards to pick the highest match.
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      pscb_pkg::entry_type nbr;
      logic                above_in;

      if (i == MAX_ENTRIES - 1) begin : g_end
         assign nbr      = wrap_entry;
         assign above_in = 1'b0;
      end else begin : g_mid
         assign nbr      = cell_q[i + 1];
         assign above_in = above[i + 1];
      end

      pscb_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .nbr_entry (nbr),
         .above_in  (above_in),
         .above_out (above[i]),
         .entry     (cell_q[i])
      );
   end

endmodule
